/* src/scpa_pkg.sv */
// Shared types, constants and helpers of the size-class pool allocator.
// Used by the allocator top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

  localparam int ADDR_W      = 25;
  localparam int SIZE_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int CLASS_W     = 3;
  localparam int SLOT_W      = 5;
  localparam int NUM_CLASSES = 6;
  localparam int KOFF_W      = 6;
  localparam int PROD_W      = 23;

  localparam int SLOTS_DEF           = 32;
  localparam int PARTITION_BYTES_DEF = 4194304;

  localparam logic [SIZE_W-1:0] DELEGATED_SIZE = 32'd8;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELEGATED = 3'd4;

  typedef logic [16:0] stride_t;

  localparam stride_t STRIDE [NUM_CLASSES] = '{
    17'd19, 17'd131, 17'd1027, 17'd8195, 17'd32771, 17'd65539
  };

  localparam logic [SIZE_W-1:0] BLOCK [NUM_CLASSES] = '{
    32'd16, 32'd128, 32'd1024, 32'd8192, 32'd32768, 32'd65536
  };

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
    logic [CLASS_W-1:0]  size_class;
    logic [SLOT_W-1:0]   slot_index;
  } out_beat_t;

  function automatic logic [ADDR_W-1:0] slot_offset(input logic [CLASS_W-1:0] cls,
                                                    input logic [KOFF_W-1:0] k);
    logic [PROD_W-1:0] stride;
    logic [PROD_W-1:0] prod;
    stride = '0;
    case (cls)
      3'd0: stride = PROD_W'(STRIDE[0]);
      3'd1: stride = PROD_W'(STRIDE[1]);
      3'd2: stride = PROD_W'(STRIDE[2]);
      3'd3: stride = PROD_W'(STRIDE[3]);
      3'd4: stride = PROD_W'(STRIDE[4]);
      3'd5: stride = PROD_W'(STRIDE[5]);
      default: stride = '0;
    endcase
    prod = PROD_W'(k) * stride;
    return ADDR_W'(prod);
  endfunction

endpackage

`default_nettype wire

/* src/size_class_pool_allocator.sv */
// Size-class pool allocator: six fixed-stride partitions with used and issued maps.
// Depends on scpa_pkg and scpa_ram.
// An accepted beat and its class map read are registered first, then the result is
// registered once the output is not stalled. No new request is taken while one is
// pending, set by the read-modify-write of the class map memory (read, modify, write).
// Reset clears one valid bit per class entry; an unwritten entry reads as all free and
// never issued, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module size_class_pool_allocator #(
  parameter int SLOTS           = scpa_pkg::SLOTS_DEF,
  parameter int PARTITION_BYTES = scpa_pkg::PARTITION_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire scpa_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output scpa_pkg::out_beat_t      out_data
);

  localparam int WORD_W = 2 * SLOTS;
  localparam int K_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CA_W   = $clog2(scpa_pkg::NUM_CLASSES);

  typedef enum logic [1:0] {
    KIND_NORM  = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_DELEG = 2'd2
  } kind_t;

  logic [SLOTS-1:0]            lim_mask  [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::ADDR_W-1:0] base_addr [scpa_pkg::NUM_CLASSES];

  for (genvar c = 0; c < scpa_pkg::NUM_CLASSES; c++) begin : g_class
    localparam int FIT  = PARTITION_BYTES / int'(scpa_pkg::STRIDE[c]);
    localparam int LIMC = (FIT < SLOTS) ? FIT : SLOTS;
    localparam logic [63:0] BASE64 = 64'(c) * 64'(PARTITION_BYTES);
    assign base_addr[c] = BASE64[scpa_pkg::ADDR_W-1:0];
    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
      assign lim_mask[c][k] = (k < LIMC);
    end
  end

  logic                  accept;
  kind_t                 in_kind;
  logic [scpa_pkg::CLASS_W-1:0] in_cls;

  logic                         pend_r;
  kind_t                        kind_r;
  logic                         op_r;
  logic [scpa_pkg::CLASS_W-1:0] cls_r;
  logic [scpa_pkg::ADDR_W-1:0]  addr_r;
  logic                         rd_valid_r;
  logic [scpa_pkg::NUM_CLASSES-1:0] valid_r;
  logic                         out_valid_r;
  scpa_pkg::out_beat_t          out_data_r;

  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] word;
  logic [SLOTS-1:0]  used;
  logic [SLOTS-1:0]  issued;
  logic [SLOTS-1:0]  mask;
  logic [scpa_pkg::ADDR_W-1:0] base;
  logic [scpa_pkg::ADDR_W-1:0] diff;
  logic [SLOTS-1:0]  avail;
  logic [SLOTS-1:0]  hit;
  logic              found_a;
  logic              found_f;
  logic [K_W-1:0]    k_a;
  logic [K_W-1:0]    k_f;
  logic              done;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  scpa_pkg::out_beat_t res;

  assign accept = in_valid && !in_stall;
  assign in_stall = pend_r;

  always_comb begin
    in_kind = KIND_BAD;
    in_cls  = '0;
    for (int c = scpa_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if (in_data.request_size <= scpa_pkg::BLOCK[c]) begin
        in_kind = KIND_NORM;
        in_cls  = scpa_pkg::CLASS_W'(c);
      end
    end
    if (in_data.request_size == scpa_pkg::DELEGATED_SIZE) begin
      in_kind = KIND_DELEG;
      in_cls  = '0;
    end
  end

  scpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(scpa_pkg::NUM_CLASSES)
  ) u_map_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(cls_r[CA_W-1:0]),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(in_cls[CA_W-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    word   = rd_valid_r ? rd_data : '0;
    used   = word[SLOTS-1:0];
    issued = word[WORD_W-1:SLOTS];
    mask   = lim_mask[cls_r];
    base   = base_addr[cls_r];
    diff   = addr_r - base;
    avail  = ~used & mask;
    for (int k = 0; k < SLOTS; k++) begin
      hit[k] = issued[k] && mask[k] &&
               (scpa_pkg::slot_offset(cls_r, scpa_pkg::KOFF_W'(k)) == diff);
    end
    found_a = 1'b0;
    found_f = 1'b0;
    k_a     = '0;
    k_f     = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (avail[k]) begin
        found_a = 1'b1;
        k_a     = K_W'(k);
      end
      if (hit[k]) begin
        found_f = 1'b1;
        k_f     = K_W'(k);
      end
    end
  end

  always_comb begin
    res     = '0;
    wr_en   = 1'b0;
    wr_data = word;
    done    = pend_r && (!out_valid_r || !out_stall);
    case (kind_r)
      KIND_DELEG: begin
        res.status = scpa_pkg::ST_DELEGATED;
      end
      KIND_BAD: begin
        res.status = scpa_pkg::ST_BAD_SIZE;
      end
      KIND_NORM: begin
        res.size_class = cls_r;
        if (!op_r) begin
          if (found_a) begin
            res.status          = scpa_pkg::ST_OK;
            res.granted_address = base +
                                  scpa_pkg::slot_offset(cls_r, scpa_pkg::KOFF_W'(k_a));
            res.slot_index      = scpa_pkg::SLOT_W'(k_a);
            wr_en               = done;
            wr_data[k_a]        = 1'b1;
            wr_data[SLOTS + int'(k_a)] = 1'b1;
          end else begin
            res.status = scpa_pkg::ST_NO_SLOT;
          end
        end else begin
          if (found_f) begin
            res.status          = scpa_pkg::ST_OK;
            res.granted_address = addr_r;
            res.slot_index      = scpa_pkg::SLOT_W'(k_f);
            wr_en               = done;
            wr_data[k_f]        = 1'b0;
          end else begin
            res.status = scpa_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
        res.status = scpa_pkg::ST_BAD_SIZE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_r <= 1'b1;
      end else if (done) begin
        pend_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[cls_r[CA_W-1:0]] <= 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r     <= in_kind;
      op_r       <= in_data.operation;
      cls_r      <= in_cls;
      addr_r     <= in_data.block_address;
      rd_valid_r <= valid_r[in_cls[CA_W-1:0]];
    end
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* src/scpa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
